// File: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off during reset.
`define AST_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion, checked at every rising edge.
`define AST_ALW(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/cop_pkg.sv
package cop_pkg;

  localparam int BE_W   = 11;  // batch_elements register
  localparam int NW_W   = 5;   // num_workers register
  localparam int SZ_W   = 13;  // output size registers
  localparam int DS_W   = 5;   // dilation / stride registers
  localparam int WK_W   = 4;
  localparam int PC_W   = 22;
  localparam int BI_W   = 10;
  localparam int CO_W   = 12;
  localparam int XE_W   = 13;
  localparam int P1_W   = BE_W + SZ_W;        // batch * rows
  localparam int TOT_W  = P1_W + SZ_W;        // element count
  localparam int MUL_W  = TOT_W + NW_W;       // worker * count
  localparam int R_W    = P1_W;               // global partial row index
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_BATCH = 3'd0;
  localparam logic [2:0] REG_NWORK = 3'd1;
  localparam logic [2:0] REG_SIZEY = 3'd2;
  localparam logic [2:0] REG_SIZEX = 3'd3;
  localparam logic [2:0] REG_DILY  = 3'd4;
  localparam logic [2:0] REG_DILX  = 3'd5;
  localparam logic [2:0] REG_STRY  = 3'd6;
  localparam logic [2:0] REG_STRX  = 3'd7;

  localparam int MAX_WORKERS_DEF    = 16;
  localparam int MAX_FIELD_SIZE_DEF = 4096;
  localparam int MAX_BATCH_DEF      = 1024;

endpackage

// File: rtl/cop_div_cell.sv
module cop_div_cell #(
  parameter int NW = 8,
  parameter int DW = 4,
  parameter int PW = 1,
  parameter int LN = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         vld_i,
  input  logic [LN-1:0][DW+NW-1:0]     acc_i,
  input  logic [DW-1:0]                den,
  input  logic [PW-1:0]                pay_i,
  output logic                         vld_o,
  output logic [LN-1:0][DW+NW-1:0]     acc_o,
  output logic [PW-1:0]                pay_o
);

  localparam int AW = DW + NW;

  logic [LN-1:0][AW-1:0] acc_nxt;
  logic [AW:0]           sh;
  logic [DW:0]           top;
  logic                  qb;
  logic                  vld_r;
  logic [LN-1:0][AW-1:0] acc_r;
  logic [PW-1:0]         pay_r;

  // one restoring step: remainder in the high bits, quotient shifts in low
  always_comb begin
    sh  = '0;
    top = '0;
    qb  = 1'b0;
    for (int l = 0; l < LN; l++) begin
      sh  = {acc_i[l], 1'b0};
      top = sh[AW:NW];
      qb  = (top >= {1'b0, den});
      if (qb) begin
        top = top - {1'b0, den};
      end
      acc_nxt[l] = {top[DW-1:0], sh[NW-1:1], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      pay_r <= pay_i;
    end
  end

  assign vld_o = vld_r;
  assign acc_o = acc_r;
  assign pay_o = pay_r;

endmodule

// File: rtl/cop_dim_unit.sv
module cop_dim_unit import cop_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DS_W-1:0] dil,
  input  logic [DS_W-1:0] str,
  input  logic [SZ_W-1:0] size,
  output logic            busy,
  output logic [DS_W-1:0] step,
  output logic [SZ_W-1:0] count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_GCD  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_CNT  = 2'd3;

  logic [1:0]      state_r;
  logic [DS_W-1:0] a_r, b_r, d_r, step_r;
  logic [SZ_W-1:0] x_r, q_r, count_r;
  logic [DS_W-1:0] d_c, s_c;

  assign d_c = (dil == '0) ? DS_W'(1) : dil;
  assign s_c = (str == '0) ? DS_W'(1) : str;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else if (start) begin
      state_r <= S_GCD;
    end else begin
      unique case (state_r)
        S_GCD: if (a_r == b_r) state_r <= S_DIV;
        S_DIV: if (x_r == SZ_W'(a_r)) state_r <= S_CNT;
        S_CNT: if (x_r <= SZ_W'(step_r)) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // subtractive gcd, then step = d / gcd, then count = ceil(size / step)
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= d_c;
      b_r <= s_c;
      d_r <= d_c;
    end else begin
      unique case (state_r)
        S_GCD: begin
          if (a_r == b_r) begin
            x_r <= SZ_W'(d_r);
            q_r <= '0;
          end else if (a_r > b_r) begin
            a_r <= a_r - b_r;
          end else begin
            b_r <= b_r - a_r;
          end
        end
        S_DIV: begin
          if (x_r == SZ_W'(a_r)) begin
            step_r <= DS_W'(q_r + 1'b1);
            x_r    <= size;
            q_r    <= '0;
          end else begin
            x_r <= x_r - SZ_W'(a_r);
            q_r <= q_r + 1'b1;
          end
        end
        S_CNT: begin
          if (x_r <= SZ_W'(step_r)) begin
            count_r <= q_r + 1'b1;
          end else begin
            x_r <= x_r - SZ_W'(step_r);
            q_r <= q_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy  = (state_r != S_IDLE);
  assign step  = step_r;
  assign count = count_r;

endmodule

// File: rtl/conv_output_partition_rows_top.sv
// Answers "partial row <piece> of worker <worker>" for a tile's output split evenly
// over num_workers. Fully pipelined: one request per cycle while in_stall is low, built from
// three chains of restoring-division cells (42 cells for the worker range, 37 for
// the row split, 24 for batch/row), each retiring one quotient bit.
// After reset and after every register write the input is stalled while the steps,
// row counts and element total are rederived, dominated by a counting loop to
// ceil(out_size/step) per dimension (both dimensions run in parallel).
module conv_output_partition_rows_top import cop_pkg::*; #(
  parameter int MAX_WORKERS    = MAX_WORKERS_DEF,
  parameter int MAX_FIELD_SIZE = MAX_FIELD_SIZE_DEF,
  parameter int MAX_BATCH      = MAX_BATCH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WK_W-1:0]   in_worker,
  input  logic [PC_W-1:0]   in_piece,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_valid_res,
  output logic [BI_W-1:0]   out_batch_index,
  output logic [CO_W-1:0]   out_row_y,
  output logic [CO_W-1:0]   out_x_begin,
  output logic [XE_W-1:0]   out_x_end,
  output logic              out_last_piece,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int N1  = MUL_W;
  localparam int D1  = NW_W;
  localparam int N2  = TOT_W;
  localparam int D2  = SZ_W;
  localparam int N3  = R_W;
  localparam int D3  = SZ_W;
  localparam int PW1 = 1 + PC_W;
  localparam int PW3 = 1 + SZ_W + SZ_W + 1;

  // ---------------- configuration ----------------
  logic [BE_W-1:0] batch_r;
  logic [NW_W-1:0] nwork_r;
  logic [SZ_W-1:0] sizey_r, sizex_r;
  logic [DS_W-1:0] dily_r, dilx_r, stry_r, strx_r;
  logic            wr;

  assign wr         = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= BE_W'(1);
      nwork_r <= NW_W'(6);
      sizey_r <= SZ_W'(1);
      sizex_r <= SZ_W'(1);
      dily_r  <= DS_W'(1);
      dilx_r  <= DS_W'(1);
      stry_r  <= DS_W'(1);
      strx_r  <= DS_W'(1);
    end else if (wr) begin
      unique case (cfg_paddr[4:2])
        REG_BATCH: batch_r <= cfg_pwdata[BE_W-1:0];
        REG_NWORK: nwork_r <= cfg_pwdata[NW_W-1:0];
        REG_SIZEY: sizey_r <= cfg_pwdata[SZ_W-1:0];
        REG_SIZEX: sizex_r <= cfg_pwdata[SZ_W-1:0];
        REG_DILY:  dily_r  <= cfg_pwdata[DS_W-1:0];
        REG_DILX:  dilx_r  <= cfg_pwdata[DS_W-1:0];
        REG_STRY:  stry_r  <= cfg_pwdata[DS_W-1:0];
        REG_STRX:  strx_r  <= cfg_pwdata[DS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_BATCH: cfg_prdata = DATA_W'(batch_r);
      REG_NWORK: cfg_prdata = DATA_W'(nwork_r);
      REG_SIZEY: cfg_prdata = DATA_W'(sizey_r);
      REG_SIZEX: cfg_prdata = DATA_W'(sizex_r);
      REG_DILY:  cfg_prdata = DATA_W'(dily_r);
      REG_DILX:  cfg_prdata = DATA_W'(dilx_r);
      REG_STRY:  cfg_prdata = DATA_W'(stry_r);
      REG_STRX:  cfg_prdata = DATA_W'(strx_r);
      default:   cfg_prdata = '0;
    endcase
  end

  logic [BE_W-1:0] nb_c;
  logic [NW_W-1:0] nw_c;
  logic [SZ_W-1:0] oy_c, ox_c;

  always_comb begin
    nb_c = batch_r;
    if (batch_r == '0) nb_c = BE_W'(1);
    else if (32'(batch_r) > MAX_BATCH) nb_c = BE_W'(MAX_BATCH);
    nw_c = nwork_r;
    if (nwork_r == '0) nw_c = NW_W'(1);
    else if (32'(nwork_r) > MAX_WORKERS) nw_c = NW_W'(MAX_WORKERS);
    oy_c = sizey_r;
    if (sizey_r == '0) oy_c = SZ_W'(1);
    else if (32'(sizey_r) > MAX_FIELD_SIZE) oy_c = SZ_W'(MAX_FIELD_SIZE);
    ox_c = sizex_r;
    if (sizex_r == '0) ox_c = SZ_W'(1);
    else if (32'(sizex_r) > MAX_FIELD_SIZE) ox_c = SZ_W'(MAX_FIELD_SIZE);
  end

  // ---------------- derived values ----------------
  logic             start_r, busy_r, ph_r;
  logic             ybusy, xbusy;
  logic [DS_W-1:0]  stepy, stepx;
  logic [SZ_W-1:0]  rows, epr;
  logic [P1_W-1:0]  p1_r;
  logic [TOT_W-1:0] total_r;

  cop_dim_unit u_dimy (
    .clk(clk), .rst_n(rst_n), .start(start_r), .dil(dily_r), .str(stry_r),
    .size(oy_c), .busy(ybusy), .step(stepy), .count(rows)
  );

  cop_dim_unit u_dimx (
    .clk(clk), .rst_n(rst_n), .start(start_r), .dil(dilx_r), .str(strx_r),
    .size(ox_c), .busy(xbusy), .step(stepx), .count(epr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      busy_r  <= 1'b1;
      ph_r    <= 1'b0;
    end else begin
      start_r <= wr;
      if (wr) begin
        busy_r <= 1'b1;
        ph_r   <= 1'b0;
      end else if (busy_r && !start_r && !ybusy && !xbusy) begin
        ph_r <= ~ph_r;
        if (ph_r) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && !start_r && !ybusy && !xbusy) begin
      if (!ph_r) p1_r <= nb_c * rows;
      else total_r <= p1_r * epr;
    end
  end

  // ---------------- request pipeline ----------------
  logic adv, out_valid_r;
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = busy_r || !adv;

  // stage 0: worker range numerators
  logic             s0_vld_r, s0_ok_r;
  logic [N1-1:0]    s0_numb_r, s0_nume_r;
  logic [PC_W-1:0]  s0_piece_r;
  logic [NW_W-1:0]  w5;

  assign w5 = {1'b0, in_worker};

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (adv) s0_vld_r <= in_valid && !busy_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ok_r    <= (w5 < nw_c);
      s0_numb_r  <= w5 * total_r;
      s0_nume_r  <= (w5 + 1'b1) * total_r;
      s0_piece_r <= in_piece;
    end
  end

  // chain 1: begin/end = numerator / num_workers
  logic [N1:0]                   c1_vld;
  logic [N1:0][1:0][D1+N1-1:0]   c1_acc;
  logic [N1:0][PW1-1:0]          c1_pay;

  assign c1_vld[0]    = s0_vld_r;
  assign c1_acc[0][0] = {D1'(0), s0_numb_r};
  assign c1_acc[0][1] = {D1'(0), s0_nume_r};
  assign c1_pay[0]    = {s0_ok_r, s0_piece_r};

  for (genvar g = 0; g < N1; g++) begin : g_c1
    cop_div_cell #(.NW(N1), .DW(D1), .PW(PW1), .LN(2)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(c1_vld[g]), .acc_i(c1_acc[g]),
      .den(nw_c), .pay_i(c1_pay[g]), .vld_o(c1_vld[g+1]), .acc_o(c1_acc[g+1]),
      .pay_o(c1_pay[g+1])
    );
  end

  // stage E: empty share check
  logic [TOT_W-1:0] beg_c, end_c;
  logic             se_vld_r, se_ok_r;
  logic [TOT_W-1:0] se_beg_r, se_endm1_r;
  logic [PC_W-1:0]  se_piece_r;

  assign beg_c = c1_acc[N1][0][TOT_W-1:0];
  assign end_c = c1_acc[N1][1][TOT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) se_vld_r <= 1'b0;
    else if (adv) se_vld_r <= c1_vld[N1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      se_ok_r    <= c1_pay[N1][PW1-1] && (beg_c < end_c);
      se_beg_r   <= beg_c;
      se_endm1_r <= end_c - 1'b1;
      se_piece_r <= c1_pay[N1][PC_W-1:0];
    end
  end

  // chain 2: row index and offset of first and last element
  logic [N2:0]                   c2_vld;
  logic [N2:0][1:0][D2+N2-1:0]   c2_acc;
  logic [N2:0][PW1-1:0]          c2_pay;

  assign c2_vld[0]    = se_vld_r;
  assign c2_acc[0][0] = {D2'(0), se_beg_r};
  assign c2_acc[0][1] = {D2'(0), se_endm1_r};
  assign c2_pay[0]    = {se_ok_r, se_piece_r};

  for (genvar g = 0; g < N2; g++) begin : g_c2
    cop_div_cell #(.NW(N2), .DW(D2), .PW(PW1), .LN(2)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(c2_vld[g]), .acc_i(c2_acc[g]),
      .den(epr), .pay_i(c2_pay[g]), .vld_o(c2_vld[g+1]), .acc_o(c2_acc[g+1]),
      .pay_o(c2_pay[g+1])
    );
  end

  // stage P: pick the requested partial row
  logic [R_W-1:0]  rb_c, rl_c, r_c;
  logic [SZ_W-1:0] xbr_c, xlr_c;
  logic [PC_W-1:0] pc_c;
  logic            sp_vld_r, sp_ok_r, sp_last_r;
  logic [R_W-1:0]  sp_r_r;
  logic [SZ_W-1:0] sp_xb_r, sp_xl_r;

  assign rb_c  = c2_acc[N2][0][R_W-1:0];
  assign rl_c  = c2_acc[N2][1][R_W-1:0];
  assign xbr_c = c2_acc[N2][0][D2+N2-1 -: SZ_W];
  assign xlr_c = c2_acc[N2][1][D2+N2-1 -: SZ_W];
  assign pc_c  = c2_pay[N2][PC_W-1:0];
  assign r_c   = rb_c + R_W'(pc_c);

  always_ff @(posedge clk) begin
    if (!rst_n) sp_vld_r <= 1'b0;
    else if (adv) sp_vld_r <= c2_vld[N2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sp_ok_r   <= c2_pay[N2][PW1-1] && (R_W'(pc_c) <= (rl_c - rb_c));
      sp_r_r    <= r_c;
      sp_xb_r   <= (pc_c == '0) ? xbr_c : '0;
      sp_xl_r   <= (r_c == rl_c) ? xlr_c : (epr - 1'b1);
      sp_last_r <= (r_c == rl_c);
    end
  end

  // chain 3: batch = r / rows, row = r % rows
  logic [N3:0]                   c3_vld;
  logic [N3:0][0:0][D3+N3-1:0]   c3_acc;
  logic [N3:0][PW3-1:0]          c3_pay;

  assign c3_vld[0]    = sp_vld_r;
  assign c3_acc[0][0] = {D3'(0), sp_r_r};
  assign c3_pay[0]    = {sp_ok_r, sp_xb_r, sp_xl_r, sp_last_r};

  for (genvar g = 0; g < N3; g++) begin : g_c3
    cop_div_cell #(.NW(N3), .DW(D3), .PW(PW3), .LN(1)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(c3_vld[g]), .acc_i(c3_acc[g]),
      .den(rows), .pay_i(c3_pay[g]), .vld_o(c3_vld[g+1]), .acc_o(c3_acc[g+1]),
      .pay_o(c3_pay[g+1])
    );
  end

  // output register: scale by the steps
  logic            ok_f, last_f;
  logic [SZ_W-1:0] rem_f, xb_f, xl_f;
  logic [R_W-1:0]  q_f;
  logic [SZ_W+DS_W-1:0] ry_m, xb_m, xe_m;
  logic            res_r, last_r;
  logic [BI_W-1:0] bi_r;
  logic [CO_W-1:0] ry_r, xb_r;
  logic [XE_W-1:0] xe_r;

  assign {ok_f, xb_f, xl_f, last_f} = c3_pay[N3];
  assign q_f   = c3_acc[N3][0][R_W-1:0];
  assign rem_f = c3_acc[N3][0][D3+N3-1 -: SZ_W];
  assign ry_m  = rem_f * stepy;
  assign xb_m  = xb_f * stepx;
  assign xe_m  = xl_f * stepx + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= c3_vld[N3];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r  <= ok_f;
      bi_r   <= ok_f ? q_f[BI_W-1:0] : '0;
      ry_r   <= ok_f ? ry_m[CO_W-1:0] : '0;
      xb_r   <= ok_f ? xb_m[CO_W-1:0] : '0;
      xe_r   <= ok_f ? xe_m[XE_W-1:0] : '0;
      last_r <= ok_f && last_f;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_r;
  assign out_batch_index = bi_r;
  assign out_row_y       = ry_r;
  assign out_x_begin     = xb_r;
  assign out_x_end       = xe_r;
  assign out_last_piece  = last_r;

endmodule

// File: rtl/cop_chk.sv
`include "assert_macros.svh"

module cop_chk import cop_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [WK_W-1:0]   in_worker,
  input logic [PC_W-1:0]   in_piece,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_valid_res,
  input logic [BI_W-1:0]   out_batch_index,
  input logic [CO_W-1:0]   out_row_y,
  input logic [CO_W-1:0]   out_x_begin,
  input logic [XE_W-1:0]   out_x_end,
  input logic              out_last_piece,
  input logic              cfg_psel,
  input logic              cfg_penable,
  input logic              cfg_pwrite,
  input logic [ADDR_W-1:0] cfg_paddr,
  input logic [DATA_W-1:0] cfg_pwdata,
  input logic [DATA_W-1:0] cfg_prdata,
  input logic              cfg_pready
);

  `AST_RST(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `AST_RST(a_inv_zero, clk, rst_n, out_valid && !out_valid_res |-> (out_batch_index == '0) && (out_row_y == '0) && (out_x_begin == '0) && (out_x_end == '0) && !out_last_piece, "invalid result not zeroed")
  `AST_RST(a_span, clk, rst_n, out_valid && out_valid_res |-> out_x_end > XE_W'(out_x_begin), "empty partial row")
  `AST_ALW(a_pready, clk, cfg_pready, "pready low")

endmodule

bind conv_output_partition_rows_top cop_chk u_cop_chk (.*);
